// File: rtl/threshold_linkage_clustering_unit_macros.svh
// Assertion macros for the threshold linkage clustering unit.
// Used by RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef THRESHOLD_LINKAGE_CLUSTERING_UNIT_MACROS_SVH
`define THRESHOLD_LINKAGE_CLUSTERING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tlc check failed");
`define TLC_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tlc check failed");
`else
`define TLC_ASSERT(lbl, prop)
`define TLC_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

// File: rtl/tlc_pkg.sv
// Shared types, constants and helpers of the threshold linkage clustering unit.
// No dependencies.
`default_nettype none
package tlc_pkg;
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned ID_W       = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned SCORE_W    = 14;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned NUM_W      = 20;
  localparam int unsigned DEN_W      = 8;
  localparam int unsigned STEP_W     = 5;

  localparam logic [MASK_W-1:0]  MSB_BIT    = 64'h8000_0000_0000_0000;
  localparam logic [SIZE_W-1:0]  SIZE_MAX   = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = '1;
  localparam logic [CNT_W-1:0]   TABLE_FULL = CNT_W'(MAX_POINTS);
  localparam logic [ID_W-1:0]    LAST_SLOT  = ID_W'(MAX_POINTS - 1);
  localparam logic [THR_W-1:0]   THR_RESET  = 12'd200;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tlc_point_t;

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]  size;
    logic [SCORE_W-1:0] score;
  } tlc_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NEAR, ST_RD, ST_EV, ST_MMUL, ST_AMUL,
    ST_DIV, ST_FIN, ST_LD, ST_LD2, ST_WB, ST_RES
  } tlc_state_e;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W:0] n);
    return (n > {1'b0, SIZE_MAX}) ? SIZE_MAX : n[SIZE_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] sat_score(input logic [SCORE_W:0] s);
    return (s > {1'b0, SCORE_MAX}) ? SCORE_MAX : s[SCORE_W-1:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/threshold_linkage_clustering_unit.sv
// Steps per point: proximity scan, then a read and check of each existing cluster
// with a centroid divide per merge, then finish, the centroid update of a joined
// point (after a load of the last slot on a full table), write back and deliver.
// One point at a time: a new point is taken only in the idle state; how long a point
// takes is set by the cluster table walk and the serial centroid divider.
// Reset: cluster count 0, threshold 200; table and positions are not cleared.
`default_nettype none
`include "threshold_linkage_clustering_unit_macros.svh"
module threshold_linkage_clustering_unit import tlc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [THR_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ID_W-1:0]    obj_id_i,
  input  wire logic [COORD_W-1:0] pos_x_i,
  input  wire logic [COORD_W-1:0] pos_y_i,
  input  wire logic [VAL_W-1:0]   point_value_i,
  input  wire logic               last_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ID_W-1:0]         cluster_index_o,
  output logic [CNT_W-1:0]        cluster_total_o,
  output logic [COORD_W-1:0]      centroid_x_o,
  output logic [COORD_W-1:0]      centroid_y_o,
  output logic [SIZE_W-1:0]       member_total_o,
  output logic [SCORE_W-1:0]      points_sum_o,
  output logic [MASK_W-1:0]       member_mask_o
);
  tlc_state_e        state_q, state_d;
  tlc_point_t        pt_q;
  logic [VAL_W-1:0]  val_q;
  logic              last_q;
  logic [THR_W-1:0]  thr_q;
  logic [CNT_W-1:0]  cnt_q, r_q, w_q;
  logic              found_q, app_q, out_valid_q;
  logic [ID_W-1:0]   first_q;
  tlc_entry_t        acc_q, rd_q, wdata;
  tlc_entry_t        mem_q [MAX_POINTS];

  logic              in_accept, out_ok, hit;
  logic              near_start, near_done;
  logic [MASK_W-1:0] near_vec, pt_bit;
  logic              mem_re, mem_we;
  logic [ID_W-1:0]   raddr, waddr;
  logic              div_start, div_x_done, div_y_done;
  logic [NUM_W-1:0]  num_x, num_y;
  logic [DEN_W-1:0]  den;
  logic [COORD_W-1:0] quo_x, quo_y;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_ok    = !(out_valid_q && out_stall_i);
  assign hit       = |(rd_q.mask & near_vec);
  assign pt_bit    = MSB_BIT >> pt_q.id;

  tlc_near u_near (
    .clk_i, .rst_ni,
    .start_i (near_start),
    .pt_i    ({obj_id_i, pos_x_i, pos_y_i}),
    .thr_i   (thr_q),
    .done_o  (near_done),
    .near_o  (near_vec)
  );

  always_comb begin
    if (state_q == ST_MMUL) begin
      num_x = NUM_W'(acc_q.size) * NUM_W'(acc_q.cx) + NUM_W'(rd_q.size) * NUM_W'(rd_q.cx);
      num_y = NUM_W'(acc_q.size) * NUM_W'(acc_q.cy) + NUM_W'(rd_q.size) * NUM_W'(rd_q.cy);
      den   = DEN_W'(acc_q.size) + DEN_W'(rd_q.size);
    end else begin
      num_x = NUM_W'(acc_q.size) * NUM_W'(acc_q.cx) + NUM_W'(pt_q.x);
      num_y = NUM_W'(acc_q.size) * NUM_W'(acc_q.cy) + NUM_W'(pt_q.y);
      den   = DEN_W'(acc_q.size) + DEN_W'(1);
    end
  end

  tlc_div u_div_x (
    .clk_i, .rst_ni, .start_i (div_start), .num_i (num_x), .den_i (den),
    .done_o (div_x_done), .quo_o (quo_x)
  );

  tlc_div u_div_y (
    .clk_i, .rst_ni, .start_i (div_start), .num_i (num_y), .den_i (den),
    .done_o (div_y_done), .quo_o (quo_y)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_NEAR;
      ST_NEAR: if (near_done) state_d = (cnt_q == '0) ? ST_FIN : ST_RD;
      ST_RD:   state_d = ST_EV;
      ST_EV: begin
        if (hit && found_q) state_d = ST_MMUL;
        else if ((r_q + CNT_W'(1)) < cnt_q) state_d = ST_RD;
        else state_d = ST_FIN;
      end
      ST_MMUL: state_d = ST_DIV;
      ST_AMUL: state_d = ST_DIV;
      ST_DIV: begin
        if (div_x_done) begin
          if (app_q) state_d = ST_WB;
          else state_d = (r_q < cnt_q) ? ST_RD : ST_FIN;
        end
      end
      ST_FIN: begin
        if (found_q) state_d = ST_AMUL;
        else state_d = (w_q == TABLE_FULL) ? ST_LD : ST_WB;
      end
      ST_LD:   state_d = ST_LD2;
      ST_LD2:  state_d = ST_AMUL;
      ST_WB:   state_d = ST_RES;
      ST_RES:  if (out_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    near_start = 1'b0;
    mem_re     = 1'b0;
    raddr      = r_q[ID_W-1:0];
    mem_we     = 1'b0;
    waddr      = w_q[ID_W-1:0];
    wdata      = rd_q;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        near_start = in_valid_i;
      end
      ST_RD:   mem_re = 1'b1;
      ST_EV:   mem_we = !hit;
      ST_MMUL, ST_AMUL: div_start = 1'b1;
      ST_LD: begin
        mem_re = 1'b1;
        raddr  = LAST_SLOT;
      end
      ST_WB: begin
        mem_we = 1'b1;
        waddr  = first_q;
        wdata  = acc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    if (mem_re) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THR_RESET;
      cnt_q       <= '0;
      r_q         <= '0;
      w_q         <= '0;
      found_q     <= 1'b0;
      app_q       <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if ((state_q == ST_RES) && out_ok) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_accept) begin
          r_q     <= '0;
          w_q     <= '0;
          found_q <= 1'b0;
          app_q   <= 1'b0;
        end
        ST_EV: begin
          r_q <= r_q + CNT_W'(1);
          if (!hit || !found_q) w_q <= w_q + CNT_W'(1);
          if (hit && !found_q) begin
            found_q <= 1'b1;
            first_q <= w_q[ID_W-1:0];
          end
        end
        ST_FIN: if (!found_q && w_q != TABLE_FULL) begin
          first_q <= w_q[ID_W-1:0];
          w_q     <= w_q + CNT_W'(1);
        end
        ST_LD2: begin
          found_q <= 1'b1;
          first_q <= LAST_SLOT;
        end
        ST_AMUL: app_q <= 1'b1;
        ST_RES: if (out_ok) begin
          cnt_q <= last_q ? '0 : w_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_accept) begin
        pt_q   <= '{id: obj_id_i, x: pos_x_i, y: pos_y_i};
        val_q  <= point_value_i;
        last_q <= last_item_i;
      end
      ST_EV: if (hit && !found_q) acc_q <= rd_q;
      ST_MMUL: begin
        acc_q.size  <= sat_size((SIZE_W+1)'(acc_q.size) + (SIZE_W+1)'(rd_q.size));
        acc_q.score <= sat_score((SCORE_W+1)'(acc_q.score) + (SCORE_W+1)'(rd_q.score));
        acc_q.mask  <= acc_q.mask | rd_q.mask;
      end
      ST_AMUL: begin
        acc_q.size  <= sat_size((SIZE_W+1)'(acc_q.size) + (SIZE_W+1)'(1));
        acc_q.score <= sat_score((SCORE_W+1)'(acc_q.score) + (SCORE_W+1)'(val_q));
        acc_q.mask  <= acc_q.mask | pt_bit;
      end
      ST_DIV: if (div_x_done) begin
        acc_q.cx <= quo_x;
        acc_q.cy <= quo_y;
      end
      ST_FIN: if (!found_q && w_q != TABLE_FULL) begin
        acc_q <= '{mask: pt_bit, cx: pt_q.x, cy: pt_q.y,
                   size: SIZE_W'(1), score: SCORE_W'(val_q)};
      end
      ST_LD2: acc_q <= rd_q;
      ST_RES: if (out_ok) begin
        cluster_index_o <= first_q;
        cluster_total_o <= w_q;
        centroid_x_o    <= acc_q.cx;
        centroid_y_o    <= acc_q.cy;
        member_total_o  <= acc_q.size;
        points_sum_o    <= acc_q.score;
        member_mask_o   <= acc_q.mask;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `TLC_ASSERT_IMPL(a_scan_order, (state_q == ST_RD) || (state_q == ST_EV), w_q <= r_q)
  `TLC_ASSERT(a_cnt_range, cnt_q <= TABLE_FULL)
  `TLC_ASSERT_IMPL(a_out_load, $rose(out_valid_q), $past(state_q) == ST_RES)
  `TLC_ASSERT_IMPL(a_merge_found, state_q == ST_MMUL, found_q)
  `TLC_ASSERT_IMPL(a_div_pair, div_x_done, div_y_done)
endmodule
`default_nettype wire

// File: rtl/tlc_div.sv
// Restoring divider, one quotient bit per cycle, for centroid means.
// Depends on tlc_pkg.
`default_nettype none
module tlc_div import tlc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  output logic                    done_o,
  output logic [COORD_W-1:0]      quo_o
);
  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DEN_W-1:0]  rem_q, den_q, rem_d;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W:0]    shifted;
  logic              ge;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[COORD_W-1:0];
endmodule
`default_nettype wire

// File: rtl/tlc_near.sv
// Position store and proximity scan: builds the mask of stored points
// within the threshold of the new point. Depends on tlc_pkg.
`default_nettype none
module tlc_near import tlc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tlc_point_t        pt_i,
  input  wire logic [THR_W-1:0]  thr_i,
  output logic                   done_o,
  output logic [MASK_W-1:0]      near_o
);
  logic [2*COORD_W-1:0] mem_q [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_q;
  logic                 busy_q, rd_vld_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [ID_W-1:0]      k_q;
  logic [COORD_W-1:0]   x_q, y_q, px, py, dx, dy, span;
  logic [THR_W-1:0]     thr_q;
  logic [MASK_W-1:0]    near_q;
  logic                 close;

  always_comb begin
    px    = rd_q[2*COORD_W-1:COORD_W];
    py    = rd_q[COORD_W-1:0];
    dx    = (x_q > px) ? x_q - px : px - x_q;
    dy    = (y_q > py) ? y_q - py : py - y_q;
    span  = (dx > dy) ? dx : dy;
    close = span <= thr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      rd_vld_q <= busy_q;
      done_q   <= rd_vld_q && (k_q == LAST_SLOT);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q[ID_W-1:0] == LAST_SLOT) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= cnt_q[ID_W-1:0];
    if (start_i) begin
      mem_q[pt_i.id] <= {pt_i.x, pt_i.y};
      x_q    <= pt_i.x;
      y_q    <= pt_i.y;
      thr_q  <= thr_i;
      near_q <= '0;
    end else if (rd_vld_q) begin
      near_q[~k_q] <= close;
    end
    if (busy_q) rd_q <= mem_q[cnt_q[ID_W-1:0]];
  end

  assign done_o = done_q;
  assign near_o = near_q;
endmodule
`default_nettype wire

// File: dv/threshold_linkage_clustering_unit_test.sv
// Testbench for threshold_linkage_clustering_unit: drives points and threshold writes,
// predicts each cluster result in a scoreboard class and compares it as a whole record.
// Depends on tlc_pkg and the unit's RTL.
`timescale 1ns / 1ps

module threshold_linkage_clustering_unit_test;
  import tlc_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]    cluster_index;
    logic [CNT_W-1:0]   cluster_total;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [SIZE_W-1:0]  member_total;
    logic [SCORE_W-1:0] points_sum;
    logic [MASK_W-1:0]  member_mask;
  } cluster_result_t;

  class cluster_scoreboard;
    bit [THR_W-1:0]   threshold;
    bit [COORD_W-1:0] px[64];
    bit [COORD_W-1:0] py[64];
    bit [MASK_W-1:0]  masks[64];
    int unsigned      cxs[64];
    int unsigned      cys[64];
    int unsigned      sizes[64];
    int unsigned      scores[64];
    int unsigned      count;
    cluster_result_t  pending[$];
    int unsigned      mismatches;

    function void reset_state();
      threshold = THR_RESET;
      count = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function bit is_near(int unsigned c, int unsigned x, int unsigned y);
      int unsigned dx;
      int unsigned dy;
      for (int k = 0; k < 64; k++) begin
        if (masks[c][63-k]) begin
          dx = (x > px[k]) ? x - px[k] : px[k] - x;
          dy = (y > py[k]) ? y - py[k] : py[k] - y;
          if ((dx > dy ? dx : dy) <= threshold) return 1;
        end
      end
      return 0;
    endfunction

    function void merge(int unsigned d, int unsigned s);
      longint unsigned tot;
      tot = sizes[d] + sizes[s];
      if (tot != 0) begin
        cxs[d] = (longint'(sizes[d]) * cxs[d] + longint'(sizes[s]) * cxs[s]) / tot;
        cys[d] = (longint'(sizes[d]) * cys[d] + longint'(sizes[s]) * cys[s]) / tot;
      end
      sizes[d] = tot > 127 ? 127 : tot;
      scores[d] = (scores[d] + scores[s] > 16383) ? 16383 : scores[d] + scores[s];
      masks[d] |= masks[s];
      count--;
      for (int unsigned k = s; k < count; k++) begin
        masks[k] = masks[k+1];
        cxs[k] = cxs[k+1];
        cys[k] = cys[k+1];
        sizes[k] = sizes[k+1];
        scores[k] = scores[k+1];
      end
    endfunction

    function void note_point(int unsigned id, int unsigned x, int unsigned y,
                             int unsigned v, bit last);
      bit found;
      int unsigned first;
      int unsigned i;
      int unsigned n;
      cluster_result_t r;
      found = 0;
      first = 0;
      i = 0;
      px[id] = COORD_W'(x);
      py[id] = COORD_W'(y);
      while (i < count) begin
        if (is_near(i, x, y)) begin
          if (!found) begin
            found = 1;
            first = i;
            i++;
          end else begin
            merge(first, i);
          end
        end else begin
          i++;
        end
      end
      if (!found && count >= MAX_POINTS) begin
        found = 1;
        first = MAX_POINTS - 1;
      end
      if (!found) begin
        first = count;
        masks[first] = MSB_BIT >> id;
        sizes[first] = 1;
        scores[first] = v;
        cxs[first] = x;
        cys[first] = y;
        count++;
      end else begin
        n = sizes[first];
        scores[first] = (scores[first] + v > 16383) ? 16383 : scores[first] + v;
        cxs[first] = (cxs[first] * n + x) / (n + 1);
        cys[first] = (cys[first] * n + y) / (n + 1);
        sizes[first] = n + 1 > 127 ? 127 : n + 1;
        masks[first] |= MSB_BIT >> id;
      end
      r.cluster_index = ID_W'(first);
      r.cluster_total = CNT_W'(count);
      r.centroid_x = COORD_W'(cxs[first]);
      r.centroid_y = COORD_W'(cys[first]);
      r.member_total = SIZE_W'(sizes[first]);
      r.points_sum = SCORE_W'(scores[first]);
      r.member_mask = masks[first];
      pending.push_back(r);
      if (last) count = 0;
    endfunction

    function void check_result(cluster_result_t got);
      cluster_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, index %0d", got.cluster_index);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp idx %0d tot %0d c %0d,%0d n %0d s %0d m %h | got idx %0d tot %0d c %0d,%0d n %0d s %0d m %h",
                   exp.cluster_index, exp.cluster_total, exp.centroid_x, exp.centroid_y,
                   exp.member_total, exp.points_sum, exp.member_mask,
                   got.cluster_index, got.cluster_total, got.centroid_x, got.centroid_y,
                   got.member_total, got.points_sum, got.member_mask);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [THR_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ID_W-1:0]    obj_id_i;
  logic [COORD_W-1:0] pos_x_i;
  logic [COORD_W-1:0] pos_y_i;
  logic [VAL_W-1:0]   point_value_i;
  logic               last_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ID_W-1:0]    cluster_index_o;
  logic [CNT_W-1:0]   cluster_total_o;
  logic [COORD_W-1:0] centroid_x_o;
  logic [COORD_W-1:0] centroid_y_o;
  logic [SIZE_W-1:0]  member_total_o;
  logic [SCORE_W-1:0] points_sum_o;
  logic [MASK_W-1:0]  member_mask_o;

  threshold_linkage_clustering_unit dut (.*);

  cluster_scoreboard board = new();
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles = 0;
  bit          timed_out = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      cluster_result_t r;
      r.cluster_index = cluster_index_o;
      r.cluster_total = cluster_total_o;
      r.centroid_x = centroid_x_o;
      r.centroid_y = centroid_y_o;
      r.member_total = member_total_o;
      r.points_sum = points_sum_o;
      r.member_mask = member_mask_o;
      board.check_result(r);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 40000 && !timed_out) begin
      timed_out = 1;
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_point(int unsigned id, int unsigned x, int unsigned y,
                            int unsigned v, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    obj_id_i <= ID_W'(id);
    pos_x_i <= COORD_W'(x);
    pos_y_i <= COORD_W'(y);
    point_value_i <= VAL_W'(v);
    last_item_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_point(id, x, y, v, last);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_threshold(int unsigned thr);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= THR_W'(thr);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.threshold = THR_W'(thr);
  endtask

  // random set: ids unique-ish, clustered coordinates around a few hubs
  task automatic send_set(int unsigned len, int unsigned spread);
    int unsigned hx[4];
    int unsigned hy[4];
    int unsigned h;
    int unsigned id;
    for (int k = 0; k < 4; k++) begin
      hx[k] = $urandom_range(4095);
      hy[k] = $urandom_range(4095);
    end
    for (int unsigned k = 0; k < len; k++) begin
      h = $urandom_range(3);
      id = ($urandom_range(9) == 0) ? $urandom_range(63) : (k % 64);
      if ($urandom_range(3) == 0)
        send_point(id, $urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                   k == len - 1);
      else
        send_point(id, (hx[h] + $urandom_range(spread)) % 4096,
                   (hy[h] + $urandom_range(spread)) % 4096, $urandom_range(255),
                   k == len - 1);
    end
  endtask

  initial begin
    int unsigned sent;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    obj_id_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    point_value_i = '0;
    last_item_i = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    board.reset_state();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, merge, repeated id, full table
    send_point(0, 0, 0, 0, 0);
    send_point(63, 4095, 4095, 255, 0);
    send_point(1, 200, 200, 255, 0);
    send_point(2, 401, 0, 170, 0);
    send_point(3, 300, 100, 85, 0);
    send_point(3, 4000, 4000, 255, 0);
    send_point(63, 2048, 2048, 1, 1);
    write_threshold(4095);
    for (int k = 0; k < 8; k++) send_point(k * 9, $urandom_range(4095),
                                           $urandom_range(4095), 255, k == 7);
    write_threshold(0);
    for (int k = 0; k < 66; k++) send_point(k % 64, k * 60, 4095 - k * 60, 255, k == 65);
    sent = 81;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 45; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 45; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      case (ph)
        0: write_threshold(200);
        3: write_threshold(4095);
        5: write_threshold(0);
        default: write_threshold($urandom_range(600));
      endcase
      while (sent < 90 + (ph + 1) * 190) begin
        int unsigned len;
        len = ($urandom_range(15) == 0) ? 70 : $urandom_range(1, 20);
        send_set(len, $urandom_range(1, 800));
        sent += len;
      end
      drain();
    end

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
